// ===== sv/lsfs_pkg.sv =====
// Shared types, constants and helpers for the LED strip frame serializer.
package lsfs_pkg;

  // Width of the LED counter. The led_count port is 16 bits wide.
  localparam int COUNT_WIDTH = 16;
  localparam int END_WIDTH   = COUNT_WIDTH - 3;
  localparam int LED_PORT_W  = 16;
  localparam int BRIGHT_W    = 5;

  // Depth of the queue between the request front end and the bit engine.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Request command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // One classified request as it travels through the queue.
  typedef struct packed {
    logic                   is_tick;
    logic [7:0]             red;
    logic [7:0]             green;
    logic [7:0]             blue;
    logic [COUNT_WIDTH-1:0] leds;
    logic [END_WIDTH-1:0]   end_bytes;
  } lsfs_item_t;

  // Head of the queue as seen by the bit engine.
  typedef struct packed {
    logic       valid;
    lsfs_item_t item;
  } lsfs_head_t;

  // LED count masked to the counter width.
  function automatic logic [COUNT_WIDTH-1:0] count_of(input logic [LED_PORT_W-1:0] raw);
    logic [LED_PORT_W+COUNT_WIDTH-1:0] wide;
    wide = (LED_PORT_W + COUNT_WIDTH)'(raw);
    return wide[COUNT_WIDTH-1:0];
  endfunction

  // Number of closing zero bytes: ceil(count / 16).
  function automatic logic [END_WIDTH-1:0] end_bytes_of(input logic [COUNT_WIDTH-1:0] cnt);
    logic [COUNT_WIDTH:0] sum;
    sum = {1'b0, cnt} + (COUNT_WIDTH + 1)'(15);
    return sum[COUNT_WIDTH:4];
  endfunction

endpackage

// ===== sv/lsfs_front.sv =====
// Request front end: decodes the command and precomputes the frame length.
module lsfs_front import lsfs_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [LED_PORT_W-1:0] in_led_count,
  input  logic                  q_full,
  output logic                  q_push,
  output lsfs_item_t            q_item
);

  logic [COUNT_WIDTH-1:0] cnt;

  assign cnt      = count_of(in_led_count);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.is_tick   = (in_cmd == CMD_TICK);
    q_item.red       = in_red;
    q_item.green     = in_green;
    q_item.blue      = in_blue;
    q_item.leds      = cnt;
    q_item.end_bytes = end_bytes_of(cnt);
  end

endmodule

// ===== sv/lsfs_queue.sv =====
// Short request queue between the front end and the bit engine.
module lsfs_queue import lsfs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lsfs_item_t push_item,
  output logic       full,
  input  logic       pop,
  output lsfs_head_t head
);

  lsfs_item_t          mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  logic                do_pop;

  assign full       = (cnt_r == QCNT_W'(QDEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== sv/lsfs_back.sv =====
// Bit engine: walks the frame sections and registers one result per request.
module lsfs_back import lsfs_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [BRIGHT_W-1:0] brightness,
  input  lsfs_head_t          head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_data_bit,
  output logic                out_bit_valid,
  output logic                out_frame_last,
  output logic                out_busy_res,
  output logic                out_load_rejected
);

  localparam logic [1:0] SEC_START = 2'd0;
  localparam logic [1:0] SEC_LED   = 2'd1;
  localparam logic [1:0] SEC_END   = 2'd2;

  logic                   active_r, active_nxt;
  logic [1:0]             section_r, section_nxt;
  logic [2:0]             bit_pos_r, bit_pos_nxt;
  logic [1:0]             byte_pos_r, byte_pos_nxt;
  logic [COUNT_WIDTH-1:0] leds_left_r, leds_left_nxt;
  logic [END_WIDTH-1:0]   end_left_r, end_left_nxt;
  logic [7:0]             red_r, green_r, blue_r;
  logic [7:0]             cur_byte;
  logic [COUNT_WIDTH-1:0] leds_dec;
  logic [END_WIDTH-1:0]   end_dec;
  logic                   do_load, do_tick;

  logic out_valid_r;
  logic data_r, data_nxt;
  logic bitv_r, bitv_nxt;
  logic last_r, last_nxt;
  logic busy_r;
  logic rej_r, rej_nxt;

  assign pop     = head.valid && (!out_valid_r || !out_stall);
  assign do_load = pop && !head.item.is_tick && !active_r;
  assign do_tick = pop && head.item.is_tick && active_r;

  assign leds_dec = leds_left_r - 1'b1;
  assign end_dec  = end_left_r - 1'b1;

  always_comb begin
    cur_byte = 8'h00;
    if (section_r == SEC_LED) begin
      case (byte_pos_r)
        2'd0:    cur_byte = {3'b111, brightness};
        2'd1:    cur_byte = blue_r;
        2'd2:    cur_byte = green_r;
        default: cur_byte = red_r;
      endcase
    end
  end

  always_comb begin
    active_nxt    = active_r;
    section_nxt   = section_r;
    bit_pos_nxt   = bit_pos_r;
    byte_pos_nxt  = byte_pos_r;
    leds_left_nxt = leds_left_r;
    end_left_nxt  = end_left_r;
    data_nxt      = 1'b0;
    bitv_nxt      = 1'b0;
    last_nxt      = 1'b0;
    rej_nxt       = pop && !head.item.is_tick && active_r;

    if (do_load) begin
      active_nxt    = 1'b1;
      section_nxt   = SEC_START;
      bit_pos_nxt   = '0;
      byte_pos_nxt  = '0;
      leds_left_nxt = head.item.leds;
      end_left_nxt  = head.item.end_bytes;
    end else if (do_tick) begin
      data_nxt    = cur_byte[~bit_pos_r];
      bitv_nxt    = 1'b1;
      bit_pos_nxt = bit_pos_r + 1'b1;
      if (bit_pos_r == 3'd7) begin
        unique case (section_r)
          SEC_START: begin
            byte_pos_nxt = byte_pos_r + 1'b1;
            if (byte_pos_r == 2'd3) begin
              if (leds_left_r != '0) begin
                section_nxt = SEC_LED;
              end else if (end_left_r != '0) begin
                section_nxt = SEC_END;
              end else begin
                active_nxt = 1'b0;
              end
            end
          end
          SEC_LED: begin
            byte_pos_nxt = byte_pos_r + 1'b1;
            if (byte_pos_r == 2'd3) begin
              leds_left_nxt = leds_dec;
              if (leds_dec == '0) begin
                if (end_left_r != '0) begin
                  section_nxt = SEC_END;
                end else begin
                  active_nxt = 1'b0;
                end
              end
            end
          end
          default: begin
            // The end section (and the unused code) sends zero bytes.
            end_left_nxt = end_dec;
            if (end_dec == '0) begin
              active_nxt = 1'b0;
            end
          end
        endcase
        last_nxt = !active_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      section_r   <= SEC_START;
      bit_pos_r   <= '0;
      byte_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r   <= active_nxt;
      section_r  <= section_nxt;
      bit_pos_r  <= bit_pos_nxt;
      byte_pos_r <= byte_pos_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    leds_left_r <= leds_left_nxt;
    end_left_r  <= end_left_nxt;
    if (do_load) begin
      red_r   <= head.item.red;
      green_r <= head.item.green;
      blue_r  <= head.item.blue;
    end
    if (pop) begin
      data_r <= data_nxt;
      bitv_r <= bitv_nxt;
      last_r <= last_nxt;
      busy_r <= active_nxt;
      rej_r  <= rej_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_bit      = data_r;
  assign out_bit_valid     = bitv_r;
  assign out_frame_last    = last_r;
  assign out_busy_res      = busy_r;
  assign out_load_rejected = rej_r;

endmodule

// ===== sv/led_strip_frame_serializer.sv =====
// An accepted request is first written into the request queue; its result is then
// registered on the outputs when the bit engine pops the request from the queue.
// Throughput: one request per cycle while out_stall is low, one bit engine step per request.
// A two-entry request queue absorbs output stalls; input stalls only when it is full.
// Reset (rst_n low, synchronous) empties the queue, drops any frame in progress and
// returns global brightness to 31.
module led_strip_frame_serializer import lsfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [BRIGHT_W-1:0]   cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_cmd,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [LED_PORT_W-1:0] in_led_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_data_bit,
  output logic                  out_bit_valid,
  output logic                  out_frame_last,
  output logic                  out_busy_res,
  output logic                  out_load_rejected
);

  // Global brightness register. The user must write it only while no request is in flight
  // (not enforced), so the bit engine can read it directly when a header byte goes out.
  logic [BRIGHT_W-1:0] brightness_r;

  logic       q_full;
  logic       q_push;
  lsfs_item_t q_item;
  logic       q_pop;
  lsfs_head_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brightness_r <= BRIGHT_W'(31);
    end else if (cfg_wr_en) begin
      brightness_r <= cfg_wr_data;
    end
  end

  // The front end classifies each request as a load or a tick and works out
  // the closing byte count of a load, so the engine only sequences bits.
  lsfs_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_red       (in_red),
    .in_green     (in_green),
    .in_blue      (in_blue),
    .in_led_count (in_led_count),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_item       (q_item)
  );

  // The queue lets the input keep flowing while a finished result waits.
  lsfs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head)
  );

  // The engine owns all frame state and decides at its own step whether a
  // load is taken or rejected, so the front end never needs frame state.
  lsfs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .brightness        (brightness_r),
    .head              (q_head),
    .pop               (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_data_bit      (out_data_bit),
    .out_bit_valid     (out_bit_valid),
    .out_frame_last    (out_frame_last),
    .out_busy_res      (out_busy_res),
    .out_load_rejected (out_load_rejected)
  );

endmodule
